### sv/slbc_pkg.sv
// Shared types, constants and reset values for the status LED blink-code controller.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package slbc_pkg;

  // Field and state widths.
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned FlagsW   = 8;
  localparam int unsigned CursorW  = 3;
  localparam int unsigned PhaseW   = 5;
  localparam int unsigned BlinkW   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Saturation point of both elapsed counters.
  localparam logic [ElapsedW-1:0] ElapsedMax = '1;

  // Blink count of a flag that is neither the camera nor the frame error.
  localparam logic [BlinkW-1:0] DefaultBlinks = 4'd3;

  // Request function codes.
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_MODE  = 2'd1,
    FUNC_SET   = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  // Steady display modes.
  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_SLOW = 2'd2,
    MODE_FAST = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_FAST_DELAY   = 3'd0,
    REG_SLOW_DELAY   = 3'd1,
    REG_PAUSE_DELAY  = 3'd2,
    REG_CAMERA_BIT   = 3'd3,
    REG_CAMERA_COUNT = 3'd4,
    REG_FRAME_BIT    = 3'd5,
    REG_FRAME_COUNT  = 3'd6
  } cfg_index_t;

  // Configuration register set.
  typedef struct packed {
    logic [ElapsedW-1:0] fast_delay;
    logic [ElapsedW-1:0] slow_delay;
    logic [ElapsedW-1:0] pause_delay;
    logic [CursorW-1:0]  camera_bit;
    logic [BlinkW-1:0]   camera_count;
    logic [CursorW-1:0]  frame_bit;
    logic [BlinkW-1:0]   frame_count;
  } cfg_t;

  // Controller state.
  typedef struct packed {
    logic [FlagsW-1:0]   error_flags;
    mode_t               display_mode;
    logic [PhaseW-1:0]   code_phase;
    logic [BlinkW-1:0]   code_blinks;
    logic [CursorW-1:0]  error_cursor;
    logic [ElapsedW-1:0] code_elapsed;
    logic [ElapsedW-1:0] steady_elapsed;
    logic                toggle_level;
    logic                pin_level;
  } state_t;

  localparam cfg_t CfgReset = '{
    fast_delay:   16'd100,
    slow_delay:   16'd500,
    pause_delay:  16'd1000,
    camera_bit:   3'd0,
    camera_count: 4'd2,
    frame_bit:    3'd1,
    frame_count:  4'd3
  };

  localparam state_t StateReset = '{
    error_flags:    '0,
    display_mode:   MODE_OFF,
    code_phase:     '0,
    code_blinks:    '0,
    error_cursor:   '0,
    code_elapsed:   '0,
    steady_elapsed: '0,
    toggle_level:   1'b0,
    pin_level:      1'b1
  };

endpackage

`default_nettype wire

### sv/slbc_cfg_regs.sv
// Configuration register file of the blink-code controller.
// Depends on slbc_pkg for the register index codes and the register set type.
`timescale 1ns / 1ps
`default_nettype none

module slbc_cfg_regs
  import slbc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                     cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write into the addressed register; unused indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FAST_DELAY:   cfg_nxt.fast_delay   = cfg_wdata;
        REG_SLOW_DELAY:   cfg_nxt.slow_delay   = cfg_wdata;
        REG_PAUSE_DELAY:  cfg_nxt.pause_delay  = cfg_wdata;
        REG_CAMERA_BIT:   cfg_nxt.camera_bit   = cfg_wdata[CursorW-1:0];
        REG_CAMERA_COUNT: cfg_nxt.camera_count = cfg_wdata[BlinkW-1:0];
        REG_FRAME_BIT:    cfg_nxt.frame_bit    = cfg_wdata[CursorW-1:0];
        REG_FRAME_COUNT:  cfg_nxt.frame_count  = cfg_wdata[BlinkW-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

### sv/slbc_next_state.sv
// Next-state logic of the blink-code controller for one request.
// Depends on slbc_pkg for the state and configuration types and the codes.
`timescale 1ns / 1ps
`default_nettype none

module slbc_next_state
  import slbc_pkg::*;
(
  input  wire state_t              st_i,
  input  wire cfg_t                cfg_i,
  input  wire logic [1:0]          func_i,
  input  wire logic [1:0]          mode_i,
  input  wire logic [FlagsW-1:0]   mask_i,
  output state_t                   st_o
);

  logic [CursorW-1:0]  cand;
  logic [CursorW-1:0]  pick_cursor;
  logic                pick_found;
  logic [BlinkW-1:0]   pick_blinks;

  logic [ElapsedW-1:0] code_inc;
  logic [ElapsedW-1:0] steady_inc;

  logic [BlinkW-1:0]   blinks0;
  logic [PhaseW-1:0]   phase0;
  logic [ElapsedW-1:0] elapsed0;
  logic [CursorW-1:0]  cursor0;
  logic [PhaseW-1:0]   span;
  logic [PhaseW-1:0]   phase_inc;
  logic [ElapsedW-1:0] dur;
  logic [ElapsedW-1:0] half;
  logic                last_phase;

  // Round-robin pick: first set flag after the cursor, the cursor itself last.
  always_comb begin
    pick_cursor = st_i.error_cursor;
    pick_found  = 1'b0;
    cand        = '0;
    for (int k = 1; k <= FlagsW; k++) begin
      cand = st_i.error_cursor + CursorW'(k);
      if (!pick_found && st_i.error_flags[cand]) begin
        pick_cursor = cand;
        pick_found  = 1'b1;
      end
    end
  end

  // Blink count of the picked flag; the camera flag wins a tie.
  always_comb begin
    if (pick_cursor == cfg_i.camera_bit) begin
      pick_blinks = cfg_i.camera_count;
    end else if (pick_cursor == cfg_i.frame_bit) begin
      pick_blinks = cfg_i.frame_count;
    end else begin
      pick_blinks = DefaultBlinks;
    end
  end

  // Saturating tick counters.
  assign code_inc   = (st_i.code_elapsed == ElapsedMax) ?
                      st_i.code_elapsed : st_i.code_elapsed + ElapsedW'(1);
  assign steady_inc = (st_i.steady_elapsed == ElapsedMax) ?
                      st_i.steady_elapsed : st_i.steady_elapsed + ElapsedW'(1);

  // Blink-code step: start a new flag if none is running, then time the phase.
  // A freshly started flag has zero elapsed time, so it cannot expire in the
  // same tick and one picker serves both the start and the wrap.
  always_comb begin
    blinks0  = st_i.code_blinks;
    phase0   = st_i.code_phase;
    elapsed0 = code_inc;
    cursor0  = st_i.error_cursor;
    if (st_i.code_blinks == '0) begin
      blinks0  = pick_blinks;
      phase0   = '0;
      elapsed0 = '0;
      cursor0  = pick_cursor;
    end
    span       = {blinks0, 1'b0};
    last_phase = phase0[0] && (span != '0) && (phase0 == span - PhaseW'(1));
    dur        = last_phase ? cfg_i.pause_delay : cfg_i.fast_delay;
    phase_inc  = phase0 + PhaseW'(1);
  end

  // Steady blink half period.
  assign half = (st_i.display_mode == MODE_SLOW) ? cfg_i.slow_delay : cfg_i.fast_delay;

  // Apply the request.
  always_comb begin
    st_o = st_i;
    case (func_t'(func_i))
      FUNC_TICK: begin
        st_o.code_elapsed   = code_inc;
        st_o.steady_elapsed = steady_inc;
        if (st_i.error_flags != '0) begin
          st_o.code_blinks  = blinks0;
          st_o.code_phase   = phase0;
          st_o.code_elapsed = elapsed0;
          st_o.error_cursor = cursor0;
          if (elapsed0 > dur) begin
            st_o.code_elapsed = '0;
            if (phase_inc >= span) begin
              st_o.code_phase   = '0;
              st_o.code_blinks  = pick_blinks;
              st_o.error_cursor = pick_cursor;
            end else begin
              st_o.code_phase = phase_inc;
            end
          end
          st_o.pin_level = st_o.code_phase[0];
        end else begin
          case (st_i.display_mode)
            MODE_OFF: st_o.pin_level = 1'b1;
            MODE_ON:  st_o.pin_level = 1'b0;
            default: begin
              if (steady_inc > half) begin
                st_o.steady_elapsed = '0;
                st_o.toggle_level   = ~st_i.toggle_level;
                st_o.pin_level      = ~st_i.toggle_level;
              end
            end
          endcase
        end
      end
      FUNC_MODE: begin
        st_o.display_mode = mode_t'(mode_i);
      end
      FUNC_SET: begin
        st_o.error_flags  = st_i.error_flags | mask_i;
        st_o.code_phase   = '0;
        st_o.code_elapsed = '0;
      end
      default: begin
        st_o.error_flags = st_i.error_flags & ~mask_i;
        if ((st_i.error_flags & ~mask_i) == '0) begin
          st_o.code_phase = '0;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/status_led_blink_code_controller_unit.sv
// Top level of the status LED blink-code controller: state and result registers.
// Depends on slbc_pkg, slbc_cfg_regs and slbc_next_state.
//
//   Channel   Direction  Handshake            Payload
//   in_       request    in_valid/in_ready    in_func, in_mode, in_error_mask
//   out_      result     out_valid/out_ready  out_pin_level, out_error_set
//   cfg_      write      cfg_we               cfg_index, cfg_wdata
//
// Each request is applied to the state in the cycle it is accepted and its
// result appears in the output register on the next cycle, so one request per
// cycle is taken. The request is accepted whenever the output register is
// empty or being read in the same cycle. A stalled output holds its result and
// blocks new requests. Synchronous reset darkens the LED and clears all flags.
`timescale 1ns / 1ps
`default_nettype none

module status_led_blink_code_controller_unit
  import slbc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_func,
  input  wire logic [1:0]          in_mode,
  input  wire logic [FlagsW-1:0]   in_error_mask,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_pin_level,
  output logic [FlagsW-1:0]        out_error_set,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t   cfg;
  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   pin_r;
  logic [FlagsW-1:0] flags_r;
  logic   accept;

  slbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  slbc_next_state u_next (
    .st_i   (state_r),
    .cfg_i  (cfg),
    .func_i (in_func),
    .mode_i (in_mode),
    .mask_i (in_error_mask),
    .st_o   (state_nxt)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // State and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StateReset;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
      end
      if (in_ready) begin
        out_valid_r <= in_valid;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      pin_r   <= state_nxt.pin_level;
      flags_r <= state_nxt.error_flags;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pin_level = pin_r;
  assign out_error_set = flags_r;

endmodule

`default_nettype wire

### tb/slbc_result_checker.sv
// Result checker for the status LED blink-code controller: predicts and compares.
// Depends on slbc_pkg for widths and codes; instantiated next to the block.
`timescale 1ns / 1ps

module slbc_result_checker
  import slbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic [1:0]          in_mode,
  input  logic [FlagsW-1:0]   in_error_mask,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                out_pin_level,
  input  logic [FlagsW-1:0]   out_error_set,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int                  fail_count,
  output int                  pending_count
);

  // Blinks shown for a flag that is neither the camera nor the frame error.
  localparam logic [BlinkW-1:0] OtherErrorBlinks = 4'd3;
  localparam logic [ElapsedW-1:0] ElapsedTop = {ElapsedW{1'b1}};

  typedef struct packed {
    logic              pin_level;
    logic [FlagsW-1:0] error_set;
  } led_result_t;

  // Shadow copy of the configuration registers.
  logic [ElapsedW-1:0] fast_ms;
  logic [ElapsedW-1:0] slow_ms;
  logic [ElapsedW-1:0] pause_ms;
  logic [CursorW-1:0]  camera_pos;
  logic [BlinkW-1:0]   camera_blinks;
  logic [CursorW-1:0]  frame_pos;
  logic [BlinkW-1:0]   frame_blinks;

  // Predicted controller state.
  logic [FlagsW-1:0]   flags;
  mode_t               steady_mode;
  logic [PhaseW-1:0]   phase;
  logic [BlinkW-1:0]   code_length;
  logic [CursorW-1:0]  cursor;
  logic [ElapsedW-1:0] code_ms;
  logic [ElapsedW-1:0] steady_ms;
  logic                toggle;
  logic                pin;

  // Results still owed by the block, oldest first.
  led_result_t awaited_results[$];

  task automatic report_mismatch(string what, logic [FlagsW-1:0] expected,
                                 logic [FlagsW-1:0] got);
    $display("[%0t] %s: expected %0h, got %0h", $time, what, expected, got);
    fail_count++;
  endtask

  // Move the cursor round-robin to the next set flag and return its blink count.
  function automatic logic [BlinkW-1:0] next_code_length();
    logic [FlagsW-1:0] hit;
    logic [FlagsW-1:0] camera_hot;
    logic [FlagsW-1:0] frame_hot;
    int i;
    hit = '0;
    for (i = 0; i < FlagsW; i++) begin
      if (hit == '0) begin
        cursor = cursor + 1'b1;
        if (flags[cursor]) hit[cursor] = 1'b1;
      end
    end
    camera_hot = '0;
    camera_hot[camera_pos] = 1'b1;
    frame_hot = '0;
    frame_hot[frame_pos] = 1'b1;
    // The camera flag is tested first, so it wins when both positions match.
    if (hit == camera_hot) return camera_blinks;
    if (hit == frame_hot) return frame_blinks;
    return OtherErrorBlinks;
  endfunction

  // Steady blink: flip the pin once the elapsed count passes the half period.
  function automatic void toggle_steady(logic [ElapsedW-1:0] half);
    if (steady_ms > half) begin
      steady_ms = '0;
      toggle = ~toggle;
      pin = toggle;
    end
  endfunction

  // Apply one request to the predicted state.
  function automatic void apply_request(func_t func, mode_t mode,
                                        logic [FlagsW-1:0] mask);
    logic [PhaseW:0]     span;
    logic [ElapsedW-1:0] limit;
    case (func)
      FUNC_TICK: begin
        if (code_ms != ElapsedTop) code_ms = code_ms + 1'b1;
        if (steady_ms != ElapsedTop) steady_ms = steady_ms + 1'b1;
        if (flags != '0) begin
          if (code_length == '0) begin
            code_length = next_code_length();
            phase = '0;
            code_ms = '0;
          end
          span = {1'b0, code_length, 1'b0};
          // The last odd phase of a run is the long pause.
          if (phase[0] && span != '0 && {1'b0, phase} == span - 1'b1) limit = pause_ms;
          else limit = fast_ms;
          if (code_ms > limit) begin
            code_ms = '0;
            phase = phase + 1'b1;
            if ({1'b0, phase} >= span) begin
              phase = '0;
              code_length = next_code_length();
            end
          end
          pin = phase[0];
        end else begin
          case (steady_mode)
            MODE_OFF:  pin = 1'b1;
            MODE_ON:   pin = 1'b0;
            MODE_SLOW: toggle_steady(slow_ms);
            default:   toggle_steady(fast_ms);
          endcase
        end
      end
      FUNC_MODE: steady_mode = mode;
      FUNC_SET: begin
        flags = flags | mask;
        phase = '0;
        code_ms = '0;
      end
      default: begin
        flags = flags & ~mask;
        if (flags == '0) phase = '0;
      end
    endcase
  endfunction

  // Watch all three ports at the rising edge.
  always @(posedge clk) begin
    led_result_t want;
    if (!rst_n) begin
      fast_ms = 16'd100;
      slow_ms = 16'd500;
      pause_ms = 16'd1000;
      camera_pos = 3'd0;
      camera_blinks = 4'd2;
      frame_pos = 3'd1;
      frame_blinks = 4'd3;
      flags = '0;
      steady_mode = MODE_OFF;
      phase = '0;
      code_length = '0;
      cursor = '0;
      code_ms = '0;
      steady_ms = '0;
      toggle = 1'b0;
      pin = 1'b1;
      awaited_results.delete();
    end else begin
      // Results leaving now belong to requests taken at earlier edges.
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no request outstanding", '0, out_error_set);
        end else begin
          want = awaited_results.pop_front();
          if (out_pin_level !== want.pin_level)
            report_mismatch("pin_level", want.pin_level, out_pin_level);
          if (out_error_set !== want.error_set)
            report_mismatch("error_set", want.error_set, out_error_set);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FAST_DELAY:   fast_ms = cfg_wdata;
          REG_SLOW_DELAY:   slow_ms = cfg_wdata;
          REG_PAUSE_DELAY:  pause_ms = cfg_wdata;
          REG_CAMERA_BIT:   camera_pos = cfg_wdata[CursorW-1:0];
          REG_CAMERA_COUNT: camera_blinks = cfg_wdata[BlinkW-1:0];
          REG_FRAME_BIT:    frame_pos = cfg_wdata[CursorW-1:0];
          REG_FRAME_COUNT:  frame_blinks = cfg_wdata[BlinkW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        apply_request(func_t'(in_func), mode_t'(in_mode), in_error_mask);
        want.pin_level = pin;
        want.error_set = flags;
        awaited_results.push_back(want);
      end
    end
    pending_count = awaited_results.size();
  end

endmodule

### tb/tb_status_led_blink_code_controller_unit.sv
// Testbench top for the status LED blink-code controller: clock, reset, stimulus, verdict.
// Depends on slbc_pkg, the block itself and slbc_result_checker.
`timescale 1ns / 1ps

module tb_status_led_blink_code_controller_unit;
  import slbc_pkg::*;

  localparam int CycleLimit = 1000000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_func;
  logic [1:0]          in_mode;
  logic [FlagsW-1:0]   in_error_mask;
  logic                out_valid;
  logic                out_ready;
  logic                out_pin_level;
  logic [FlagsW-1:0]   out_error_set;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_left = 0;
  int stretch_left = 0;
  int stall_style = 0;
  bit start_hold = 1'b0;
  bit free_run = 1'b0;

  status_led_blink_code_controller_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_mode       (in_mode),
    .in_error_mask (in_error_mask),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pin_level (out_pin_level),
    .out_error_set (out_error_set),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  slbc_result_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_mode       (in_mode),
    .in_error_mask (in_error_mask),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pin_level (out_pin_level),
    .out_error_set (out_error_set),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[status_led_blink_code_controller_unit] ERROR");
      $finish;
    end
  end

  // Result side: stretches of changing stall styles, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (start_hold) begin
        start_hold = 1'b0;
        hold_left = 400;
      end
      if (free_run) begin
        out_ready <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stall_style = $urandom_range(0, 2);
          stretch_left = $urandom_range(8, 60);
        end
        stretch_left--;
        case (stall_style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one request; requests come in bursts with random gaps between them.
  task automatic offer(func_t f, mode_t m, logic [FlagsW-1:0] mask);
    int gap;
    if (!free_run && burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_func <= f;
    in_mode <= m;
    in_error_mask <= mask;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Program every register; narrow registers get random junk in the unused bits.
  task automatic program_regs(logic [ElapsedW-1:0] fast, logic [ElapsedW-1:0] slow,
                              logic [ElapsedW-1:0] pause, logic [CursorW-1:0] cam_bit,
                              logic [BlinkW-1:0] cam_cnt, logic [CursorW-1:0] frm_bit,
                              logic [BlinkW-1:0] frm_cnt);
    write_reg(REG_FAST_DELAY, fast);
    write_reg(REG_SLOW_DELAY, slow);
    write_reg(REG_PAUSE_DELAY, pause);
    write_reg(REG_CAMERA_BIT, {13'($urandom), cam_bit});
    write_reg(REG_CAMERA_COUNT, {12'($urandom), cam_cnt});
    write_reg(REG_FRAME_BIT, {13'($urandom), frm_bit});
    write_reg(REG_FRAME_COUNT, {12'($urandom), frm_cnt});
  endtask

  // Mostly short blink runs, sometimes long ones, sometimes a zero count.
  function automatic logic [BlinkW-1:0] random_count();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return BlinkW'($urandom_range(7, 15));
    return BlinkW'($urandom_range(1, 4));
  endfunction

  initial begin
    int phase_no;
    int n;
    int pick;
    int r;
    func_t f;
    logic [FlagsW-1:0] mask;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_TICK;
    in_mode = MODE_OFF;
    in_error_mask = '0;
    cfg_we = 1'b0;
    cfg_index = REG_FAST_DELAY;
    cfg_wdata = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, steady modes, a zero set mask and a clear of nothing.
    offer(FUNC_TICK, MODE_OFF, 8'h00);
    offer(FUNC_MODE, MODE_ON, 8'h00);
    offer(FUNC_TICK, MODE_OFF, 8'h00);
    offer(FUNC_SET, MODE_OFF, 8'h00);
    offer(FUNC_CLEAR, MODE_OFF, 8'hFF);
    wait_drained();
    write_reg(REG_FAST_DELAY, 16'd1);
    write_reg(REG_SLOW_DELAY, 16'd1);
    write_reg(REG_PAUSE_DELAY, 16'd2);

    // Directed: both blink modes, the camera code, a high flag, then back to steady.
    offer(FUNC_MODE, MODE_SLOW, 8'h00);
    repeat (3) offer(FUNC_TICK, MODE_OFF, 8'h00);
    offer(FUNC_MODE, MODE_FAST, 8'h00);
    repeat (2) offer(FUNC_TICK, MODE_OFF, 8'h00);
    offer(FUNC_SET, MODE_OFF, 8'h01);
    repeat (4) offer(FUNC_TICK, MODE_OFF, 8'h00);
    offer(FUNC_SET, MODE_OFF, 8'h80);
    repeat (3) offer(FUNC_TICK, MODE_OFF, 8'h00);
    offer(FUNC_CLEAR, MODE_OFF, 8'h81);
    offer(FUNC_MODE, MODE_OFF, 8'h00);
    offer(FUNC_TICK, MODE_OFF, 8'h00);

    // Random phases, each under its own register settings.
    for (phase_no = 0; phase_no < 10; phase_no++) begin
      wait_drained();
      case (phase_no)
        0: program_regs(16'd0, 16'd0, 16'd0, 3'd7, 4'd15, 3'd0, 4'd1);
        // Equal flag positions: the camera count must win.
        1: program_regs(16'd1, 16'd3, 16'd2, 3'd3, 4'd1, 3'd3, 4'd15);
        // Zero blink counts on both named errors.
        2: program_regs(16'd2, 16'd1, 16'd4, 3'd5, 4'd0, 3'd6, 4'd0);
        default: program_regs(ElapsedW'($urandom_range(0, 5)), ElapsedW'($urandom_range(0, 8)),
                              ElapsedW'($urandom_range(0, 10)), CursorW'($urandom),
                              random_count(), CursorW'($urandom), random_count());
      endcase
      // Long receiver hold-off while requests keep coming.
      if (phase_no == 3) start_hold = 1'b1;
      for (n = 0; n < 130; n++) begin
        if (phase_no == 5 && n == 65) wait_drained();
        pick = $urandom_range(0, 99);
        f = (pick < 64) ? FUNC_TICK : (pick < 74) ? FUNC_MODE :
            (pick < 87) ? FUNC_SET : FUNC_CLEAR;
        r = $urandom_range(0, 7);
        if (r == 0) mask = 8'h00;
        else if (r == 1) mask = 8'hFF;
        else if (r < 5) mask = 8'h01 << $urandom_range(0, 7);
        else mask = FlagsW'($urandom);
        offer(f, mode_t'($urandom_range(0, 3)), mask);
      end
    end

    // Longest durations: neither the blink code nor the slow blink moves
    // during a short back-to-back run.
    wait_drained();
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd2, 4'd5, 3'd6, 4'd4);
    free_run = 1'b1;
    offer(FUNC_SET, MODE_OFF, 8'h44);
    offer(FUNC_MODE, MODE_SLOW, 8'h00);
    repeat (40) offer(FUNC_TICK, MODE_OFF, 8'h00);
    offer(FUNC_CLEAR, MODE_OFF, 8'hFF);
    repeat (20) offer(FUNC_TICK, MODE_OFF, 8'h00);
    free_run = 1'b0;

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("[status_led_blink_code_controller_unit] OK");
    end else begin
      $display("[status_led_blink_code_controller_unit] ERROR");
    end
    $finish;
  end

endmodule
